// File: rtl/cbtp_pkg.sv
// ----------------------------------------------------------------------------
// cbtp_pkg - shared types and constants of the color bar pattern generator
// Register indexes, default widths, bar color table and cursor colors.
// ----------------------------------------------------------------------------
package cbtp_pkg;

  // default widths handed to the top level parameters
  localparam int DEF_COORD_BITS       = 12;
  localparam int DEF_FRAME_COUNT_BITS = 32;

  // frame-number remainder: bits of the count consumed per pipeline stage
  localparam int MOD_STEP_BITS  = 4;
  // ramp divider: quotient bits resolved per pipeline stage
  localparam int GRAY_BITS      = 8;
  localparam int RAMP_STEP_BITS = 4;
  localparam int RAMP_STAGES    = GRAY_BITS / RAMP_STEP_BITS;

  // bars and pixel layout
  localparam int BAR_COUNT    = 8;
  localparam int BAR_IDX_BITS = 3;
  localparam int PIXEL_BITS   = 3 * GRAY_BITS;

  // cursor moves four columns per frame; half widths of the cursor
  localparam int CURSOR_STEP_SHIFT = 2;
  localparam int BAR_CURSOR_HALF   = 2;
  localparam int RAMP_CURSOR_HALF  = 3;

  // configuration port
  localparam int CFG_INDEX_BITS     = 2;
  localparam int RESET_FRAME_WIDTH  = 640;
  localparam int RESET_FRAME_HEIGHT = 360;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    REG_FRAME_WIDTH  = 2'd0,
    REG_FRAME_HEIGHT = 2'd1,
    REG_BYTE_ORDER   = 2'd2
  } cfg_reg_t;

  typedef enum logic {
    ORDER_RGB = 1'b0,
    ORDER_BGR = 1'b1
  } byte_order_t;

  typedef logic [GRAY_BITS-1:0] byte_t;

  typedef struct packed {
    byte_t r;
    byte_t g;
    byte_t b;
  } rgb_t;

  localparam rgb_t CURSOR_BAR_COLOR  = '{r: 8'd255, g: 8'd255, b: 8'd255};
  localparam rgb_t CURSOR_RAMP_COLOR = '{r: 8'd255, g: 8'd0,   b: 8'd0};

  // SMPTE bar order: white, yellow, cyan, green, magenta, red, blue, black
  function automatic rgb_t bar_color(input logic [BAR_IDX_BITS-1:0] idx);
    rgb_t c;
    case (idx)
      3'd0:    c = '{r: 8'd235, g: 8'd235, b: 8'd235};
      3'd1:    c = '{r: 8'd219, g: 8'd219, b: 8'd16};
      3'd2:    c = '{r: 8'd16,  g: 8'd219, b: 8'd219};
      3'd3:    c = '{r: 8'd16,  g: 8'd219, b: 8'd16};
      3'd4:    c = '{r: 8'd219, g: 8'd16,  b: 8'd219};
      3'd5:    c = '{r: 8'd219, g: 8'd16,  b: 8'd16};
      3'd6:    c = '{r: 8'd16,  g: 8'd16,  b: 8'd219};
      default: c = '{r: 8'd16,  g: 8'd16,  b: 8'd16};
    endcase
    return c;
  endfunction

endpackage

// File: rtl/cbtp_cfg.sv
// ----------------------------------------------------------------------------
// cbtp_cfg - configuration registers
// Holds width, height and byte order, and registers the values derived from
// them: effective width, bar edge columns and the first ramp line.
// ----------------------------------------------------------------------------
module cbtp_cfg import cbtp_pkg::*; #(
  parameter int COORD_BITS = DEF_COORD_BITS
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  wr_en,
  input  logic [CFG_INDEX_BITS-1:0]             wr_index,
  input  logic [COORD_BITS-1:0]                 wr_data,
  output logic [COORD_BITS-1:0]                 w_eff,
  output logic [BAR_COUNT-2:0][COORD_BITS-1:0]  bar_edge,
  output logic [COORD_BITS-1:0]                 top_line,
  output logic                                  byte_order
);

  logic [COORD_BITS-1:0]                frame_width;
  logic [COORD_BITS-1:0]                frame_height;
  logic [COORD_BITS-1:0]                w_next;
  logic [COORD_BITS-1:0]                bar_w;
  logic [BAR_COUNT-2:0][COORD_BITS-1:0] bar_edge_next;
  logic [COORD_BITS+1:0]                h_times3;
  logic [COORD_BITS-1:0]                top_next;

  // register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= COORD_BITS'(RESET_FRAME_WIDTH);
      frame_height <= COORD_BITS'(RESET_FRAME_HEIGHT);
      byte_order   <= ORDER_RGB;
    end else if (wr_en) begin
      case (cfg_reg_t'(wr_index))
        REG_FRAME_WIDTH:  frame_width  <= wr_data;
        REG_FRAME_HEIGHT: frame_height <= wr_data;
        REG_BYTE_ORDER:   byte_order   <= wr_data[0];
        default: ;
      endcase
    end
  end

  // derived values: zero width acts as one, narrow bars are one column wide
  always_comb begin
    w_next = (frame_width == '0) ? COORD_BITS'(1) : frame_width;
    bar_w  = w_next >> 3;
    if (bar_w == '0) begin
      bar_w = COORD_BITS'(1);
    end
    // edge k sits at (k+1) bar widths; below the width once the width is eight or more
    for (int k = 0; k < BAR_COUNT - 1; k++) begin
      bar_edge_next[k] = COORD_BITS'(bar_w * (k + 1));
    end
    h_times3 = {2'b00, frame_height} + {1'b0, frame_height, 1'b0};
    top_next = h_times3[COORD_BITS+1:2];
  end

  // derived values are registered again behind the configuration registers
  always_ff @(posedge clk) begin
    w_eff    <= w_next;
    bar_edge <= bar_edge_next;
    top_line <= top_next;
  end

endmodule

// File: rtl/cbtp_mod_stage.sv
// ----------------------------------------------------------------------------
// cbtp_mod_stage - one stage of the remainder and ramp divider pipeline
// Folds MOD_STEP_BITS bits of the frame count into the running remainder
// modulo the width; the first stages also resolve ramp quotient bits.
// ----------------------------------------------------------------------------
module cbtp_mod_stage import cbtp_pkg::*; #(
  parameter int COORD_BITS     = DEF_COORD_BITS,
  parameter int FRAME_PAD_BITS = DEF_FRAME_COUNT_BITS,
  parameter int STAGE          = 0
) (
  input  logic                           clk,
  input  logic                           en,
  input  logic [COORD_BITS-1:0]          w,
  input  logic [COORD_BITS-1:0]          x_in,
  input  logic [COORD_BITS-1:0]          y_in,
  input  logic [FRAME_PAD_BITS-1:0]      frame_in,
  input  logic [COORD_BITS-1:0]          rem_in,
  input  logic [COORD_BITS+GRAY_BITS-1:0] num_in,
  input  logic [GRAY_BITS-1:0]           gray_in,
  input  logic                           sat_in,
  output logic [COORD_BITS-1:0]          x_q,
  output logic [COORD_BITS-1:0]          y_q,
  output logic [FRAME_PAD_BITS-1:0]      frame_q,
  output logic [COORD_BITS-1:0]          rem_q,
  output logic [COORD_BITS+GRAY_BITS-1:0] num_q,
  output logic [GRAY_BITS-1:0]           gray_q,
  output logic                           sat_q
);

  localparam int NUM_BITS = COORD_BITS + GRAY_BITS;
  localparam int TOP_BIT  = FRAME_PAD_BITS - 1 - MOD_STEP_BITS * STAGE;

  logic [COORD_BITS:0]    r;
  logic [COORD_BITS-1:0]  rem_next;
  logic [NUM_BITS-1:0]    num_next;
  logic [GRAY_BITS-1:0]   gray_next;
  logic                   sat_next;

  // restoring remainder, most significant frame bits first
  always_comb begin
    r = {1'b0, rem_in};
    for (int j = 0; j < MOD_STEP_BITS; j++) begin
      r = {r[COORD_BITS-1:0], frame_in[TOP_BIT-j]};
      if (r >= {1'b0, w}) begin
        r = r - {1'b0, w};
      end
    end
    rem_next = r[COORD_BITS-1:0];
  end

  // ramp quotient bits, x*255 / w, in the first stages only
  if (STAGE < RAMP_STAGES) begin : g_ramp
    logic [NUM_BITS-1:0] d;
    always_comb begin
      num_next  = num_in;
      gray_next = gray_in;
      d         = '0;
      for (int j = 0; j < RAMP_STEP_BITS; j++) begin
        d = NUM_BITS'(w) << (GRAY_BITS - 1 - RAMP_STEP_BITS * STAGE - j);
        if (num_next >= d) begin
          num_next = num_next - d;
          gray_next[GRAY_BITS-1-RAMP_STEP_BITS*STAGE-j] = 1'b1;
        end
      end
      // column at or past the width saturates the ramp
      sat_next = (STAGE == 0) ? (x_in >= w) : sat_in;
    end
  end else begin : g_pass
    always_comb begin
      num_next  = num_in;
      gray_next = gray_in;
      sat_next  = sat_in;
    end
  end

  // stage register
  always_ff @(posedge clk) begin
    if (en) begin
      x_q     <= x_in;
      y_q     <= y_in;
      frame_q <= frame_in;
      rem_q   <= rem_next;
      num_q   <= num_next;
      gray_q  <= gray_next;
      sat_q   <= sat_next;
    end
  end

endmodule

// File: rtl/cbtp_color.sv
// ----------------------------------------------------------------------------
// cbtp_color - cursor, bar select and pixel output stages
// Stage A reduces the cursor column and picks bar and ramp level; stage B
// applies the cursor overlay and byte order into the output register.
// ----------------------------------------------------------------------------
module cbtp_color import cbtp_pkg::*; #(
  parameter int COORD_BITS = DEF_COORD_BITS
) (
  input  logic                                  clk,
  input  logic                                  en_a,
  input  logic                                  en_b,
  input  logic [COORD_BITS-1:0]                 w,
  input  logic [BAR_COUNT-2:0][COORD_BITS-1:0]  bar_edge,
  input  logic [COORD_BITS-1:0]                 top_line,
  input  logic                                  byte_order,
  input  logic [COORD_BITS-1:0]                 x,
  input  logic [COORD_BITS-1:0]                 y,
  input  logic [COORD_BITS-1:0]                 rem,
  input  logic [GRAY_BITS-1:0]                  gray,
  input  logic                                  sat,
  output logic [PIXEL_BITS-1:0]                 pixel
);

  localparam int T_BITS = COORD_BITS + CURSOR_STEP_SHIFT;

  logic [T_BITS-1:0]        t;
  logic [COORD_BITS-1:0]    cursor_next;
  logic [BAR_IDX_BITS-1:0]  idx_next;
  logic [COORD_BITS-1:0]    a_x;
  logic [COORD_BITS-1:0]    a_cursor;
  logic [BAR_IDX_BITS-1:0]  a_idx;
  logic                     a_top;
  logic [GRAY_BITS-1:0]     a_level;
  logic [COORD_BITS-1:0]    cur_gap;
  rgb_t                     px;
  logic [PIXEL_BITS-1:0]    pixel_next;

  // stage A: cursor = (4 * (frame mod w)) mod w, bar index by edge count
  always_comb begin
    t = {rem, {CURSOR_STEP_SHIFT{1'b0}}};
    if (t >= {1'b0, w, 1'b0}) begin
      t = t - {1'b0, w, 1'b0};
    end
    if (t >= T_BITS'(w)) begin
      t = t - T_BITS'(w);
    end
    cursor_next = t[COORD_BITS-1:0];
    idx_next = '0;
    for (int k = 0; k < BAR_COUNT - 1; k++) begin
      idx_next = idx_next + BAR_IDX_BITS'(x >= bar_edge[k]);
    end
  end

  always_ff @(posedge clk) begin
    if (en_a) begin
      a_x      <= x;
      a_cursor <= cursor_next;
      a_idx    <= idx_next;
      a_top    <= (y < top_line);
      a_level  <= sat ? {GRAY_BITS{1'b1}} : gray;
    end
  end

  // stage B: cursor overlay and byte order
  always_comb begin
    cur_gap = (a_x >= a_cursor) ? (a_x - a_cursor) : (a_cursor - a_x);
    if (a_top) begin
      px = bar_color(a_idx);
      if (cur_gap <= COORD_BITS'(BAR_CURSOR_HALF)) begin
        px = CURSOR_BAR_COLOR;
      end
    end else begin
      px = '{r: a_level, g: a_level, b: a_level};
      if (cur_gap <= COORD_BITS'(RAMP_CURSOR_HALF)) begin
        px = CURSOR_RAMP_COLOR;
      end
    end
    if (byte_order == ORDER_BGR) begin
      pixel_next = {px.r, px.g, px.b};
    end else begin
      pixel_next = {px.b, px.g, px.r};
    end
  end

  always_ff @(posedge clk) begin
    if (en_b) begin
      pixel <= pixel_next;
    end
  end

endmodule

// File: rtl/color_bar_test_pattern_pixel.sv
// ----------------------------------------------------------------------------
// color_bar_test_pattern_pixel - animated SMPTE color bar pixel generator
// Pipeline: an input capture stage, then the frame-count remainder chain that
//   folds 4 bits of the count per stage, then color stages A and B.
// Throughput: one pixel per cycle while m_tready is high; each stage stalls only when full.
// Reset (rst, synchronous): clears all valid bits, width 640, height 360, RGB.
// ----------------------------------------------------------------------------
module color_bar_test_pattern_pixel import cbtp_pkg::*; #(
  parameter  int COORD_BITS       = DEF_COORD_BITS,
  parameter  int FRAME_COUNT_BITS = DEF_FRAME_COUNT_BITS,
  localparam int IN_BITS = ((2 * COORD_BITS + FRAME_COUNT_BITS + 7) / 8) * 8
) (
  input  logic                      clk,
  input  logic                      rst,
  // input pixel request
  input  logic                      s_tvalid,
  output logic                      s_tready,
  input  logic [IN_BITS-1:0]        s_tdata,   // pixel_x, pixel_y, frame_number
  // output pixel
  output logic                      m_tvalid,
  input  logic                      m_tready,
  output logic [PIXEL_BITS-1:0]     m_tdata,   // first_byte, second_byte, third_byte
  // configuration writes
  input  logic                      wr_en,
  input  logic [CFG_INDEX_BITS-1:0] wr_index,
  input  logic [COORD_BITS-1:0]     wr_data
);

  localparam int MOD_STAGES = (FRAME_COUNT_BITS + MOD_STEP_BITS - 1) / MOD_STEP_BITS;
  localparam int FRAME_PAD_BITS = MOD_STAGES * MOD_STEP_BITS;
  localparam int NUM_BITS   = COORD_BITS + GRAY_BITS;
  localparam int STAGES     = MOD_STAGES + 3;
  localparam int STG_A      = MOD_STAGES + 1;
  localparam int STG_B      = MOD_STAGES + 2;

  logic [COORD_BITS-1:0]                w_eff;
  logic [BAR_COUNT-2:0][COORD_BITS-1:0] bar_edge;
  logic [COORD_BITS-1:0]                top_line;
  logic                                 byte_order;

  logic [STAGES-1:0]  vld;
  logic [STAGES-1:0]  vld_in;
  logic [STAGES:0]    rdy;

  logic [COORD_BITS-1:0]     x_s     [0:MOD_STAGES];
  logic [COORD_BITS-1:0]     y_s     [0:MOD_STAGES];
  logic [FRAME_PAD_BITS-1:0] frame_s [0:MOD_STAGES];
  logic [COORD_BITS-1:0]     rem_s   [0:MOD_STAGES];
  logic [NUM_BITS-1:0]       num_s   [0:MOD_STAGES];
  logic [GRAY_BITS-1:0]      gray_s  [0:MOD_STAGES];
  logic                      sat_s   [0:MOD_STAGES];

  logic [COORD_BITS-1:0]     in_x;

  // configuration
  cbtp_cfg #(.COORD_BITS(COORD_BITS)) u_cfg (
    .clk        (clk),
    .rst        (rst),
    .wr_en      (wr_en),
    .wr_index   (wr_index),
    .wr_data    (wr_data),
    .w_eff      (w_eff),
    .bar_edge   (bar_edge),
    .top_line   (top_line),
    .byte_order (byte_order)
  );

  // stall chain: a stage loads when empty or when its content moves on
  assign rdy[STAGES] = m_tready;
  for (genvar k = 0; k < STAGES; k++) begin : g_rdy
    assign rdy[k] = !vld[k] || rdy[k+1];
  end

  assign vld_in = {vld[STAGES-2:0], s_tvalid};

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      for (int k = 0; k < STAGES; k++) begin
        if (rdy[k]) begin
          vld[k] <= vld_in[k];
        end
      end
    end
  end

  assign s_tready = rdy[0];
  assign m_tvalid = vld[STAGES-1];

  // stage 0: capture the transfer, ramp numerator x*255
  assign in_x = s_tdata[COORD_BITS-1:0];

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      x_s[0]     <= in_x;
      y_s[0]     <= s_tdata[2*COORD_BITS-1:COORD_BITS];
      frame_s[0] <= FRAME_PAD_BITS'(s_tdata[2*COORD_BITS+FRAME_COUNT_BITS-1:2*COORD_BITS]);
      rem_s[0]   <= '0;
      num_s[0]   <= {in_x, {GRAY_BITS{1'b0}}} - NUM_BITS'(in_x);
      gray_s[0]  <= '0;
      sat_s[0]   <= 1'b0;
    end
  end

  // remainder and ramp divider stages
  for (genvar j = 0; j < MOD_STAGES; j++) begin : g_mod
    cbtp_mod_stage #(
      .COORD_BITS     (COORD_BITS),
      .FRAME_PAD_BITS (FRAME_PAD_BITS),
      .STAGE          (j)
    ) u_stage (
      .clk      (clk),
      .en       (rdy[j+1]),
      .w        (w_eff),
      .x_in     (x_s[j]),
      .y_in     (y_s[j]),
      .frame_in (frame_s[j]),
      .rem_in   (rem_s[j]),
      .num_in   (num_s[j]),
      .gray_in  (gray_s[j]),
      .sat_in   (sat_s[j]),
      .x_q      (x_s[j+1]),
      .y_q      (y_s[j+1]),
      .frame_q  (frame_s[j+1]),
      .rem_q    (rem_s[j+1]),
      .num_q    (num_s[j+1]),
      .gray_q   (gray_s[j+1]),
      .sat_q    (sat_s[j+1])
    );
  end

  // cursor, bar select and output register
  cbtp_color #(.COORD_BITS(COORD_BITS)) u_color (
    .clk        (clk),
    .en_a       (rdy[STG_A]),
    .en_b       (rdy[STG_B]),
    .w          (w_eff),
    .bar_edge   (bar_edge),
    .top_line   (top_line),
    .byte_order (byte_order),
    .x          (x_s[MOD_STAGES]),
    .y          (y_s[MOD_STAGES]),
    .rem        (rem_s[MOD_STAGES]),
    .gray       (gray_s[MOD_STAGES]),
    .sat        (sat_s[MOD_STAGES]),
    .pixel      (m_tdata)
  );

  // assertions
  a_full_stall: assert property (@(posedge clk) disable iff (rst)
    ((&vld) && !m_tready) |-> !s_tready)
    else $error("input accepted while pipeline full and stalled");

  a_empty_out: assert property (@(posedge clk) disable iff (rst)
    !m_tvalid |-> s_tready)
    else $error("input blocked with empty output stage");

  a_rem_range: assert property (@(posedge clk) disable iff (rst)
    vld[MOD_STAGES] |-> (rem_s[MOD_STAGES] < w_eff))
    else $error("frame remainder not below width");

endmodule
